// File: hdl/afe_pkg.sv
// shared types, constants and helpers for the frame encoder
`timescale 1ns / 1ps
package afe_pkg;

  localparam int FrameLong = 22;
  localparam int TailLen   = 8;
  localparam int IdxW      = $clog2(FrameLong);

  localparam logic [1:0] FmtNone = 2'd0;
  localparam logic [1:0] FmtTwo  = 2'd1;
  localparam logic [1:0] FmtFour = 2'd2;

  localparam logic [7:0] AsciiM     = 8'h4D;
  localparam logic [7:0] AsciiS     = 8'h53;
  localparam logic [7:0] AsciiT     = 8'h54;
  localparam logic [7:0] AsciiP     = 8'h50;
  localparam logic [7:0] AsciiC     = 8'h43;
  localparam logic [7:0] AsciiEq    = 8'h3D;
  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiComma = 8'h2C;
  localparam logic [7:0] AsciiCr    = 8'h0D;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiUpA   = 8'h41;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] char_out;
  } cell_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = AsciiZero + {4'd0, nib};
    end else begin
      c = AsciiUpA + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: hdl/afe_if.sv
// request and byte stream channel interfaces
`timescale 1ns / 1ps
interface afe_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] primary;
  logic [15:0] secondary;
  logic [1:0]  sec_fmt;

  modport source (output valid, kind, primary, secondary, sec_fmt, input ready);
  modport sink   (input valid, kind, primary, secondary, sec_fmt, output ready);
endinterface

interface afe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

// File: hdl/afe_cell.sv
// one byte cell of the output shift chain
`timescale 1ns / 1ps
module afe_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           shift,
  input  afe_pkg::cell_t load_d,
  input  afe_pkg::cell_t nbr_d,
  output afe_pkg::cell_t q
);

  logic       valid_r;
  logic       last_r;
  logic [7:0] char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_d.valid;
    end else if (shift) begin
      valid_r <= nbr_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= load_d.last;
      char_r <= load_d.char_out;
    end else if (shift) begin
      last_r <= nbr_d.last;
      char_r <= nbr_d.char_out;
    end
  end

  assign q = '{valid: valid_r, last: last_r, char_out: char_r};

endmodule

// File: hdl/afe_frame_gen.sv
// lays out the frame bytes and checksum of one request
`timescale 1ns / 1ps
module afe_frame_gen (
  input  logic           kind,
  input  logic [15:0]    primary,
  input  logic [15:0]    secondary,
  input  logic [1:0]     sec_fmt,
  output afe_pkg::cell_t frame [afe_pkg::FrameLong]
);

  logic [9:0]               sum;
  logic [15:0]              chk;
  logic [afe_pkg::IdxW-1:0] tail_base;
  logic [7:0]               bytes [afe_pkg::FrameLong];
  logic [7:0]               tail  [afe_pkg::TailLen];
  logic [afe_pkg::IdxW-1:0] last_idx;

  always_comb begin
    sum = {2'd0, primary[15:8]} + {2'd0, primary[7:0]}
        + {2'd0, secondary[15:8]} + {2'd0, secondary[7:0]};
    chk = ~{6'd0, sum};
  end

  always_comb begin
    for (int i = 0; i < afe_pkg::FrameLong; i++) begin
      bytes[i] = 8'd0;
    end
    bytes[0] = kind ? afe_pkg::AsciiS : afe_pkg::AsciiM;
    bytes[1] = afe_pkg::AsciiT;
    bytes[2] = afe_pkg::AsciiSpace;
    bytes[3] = afe_pkg::AsciiP;
    bytes[4] = afe_pkg::AsciiEq;
    bytes[5] = afe_pkg::hex_char(primary[15:12]);
    bytes[6] = afe_pkg::hex_char(primary[11:8]);
    bytes[7] = afe_pkg::hex_char(primary[7:4]);
    bytes[8] = afe_pkg::hex_char(primary[3:0]);
    case (sec_fmt)
      afe_pkg::FmtTwo: begin
        bytes[9]  = afe_pkg::AsciiComma;
        bytes[10] = afe_pkg::hex_char(secondary[7:4]);
        bytes[11] = afe_pkg::hex_char(secondary[3:0]);
        tail_base = afe_pkg::IdxW'(12);
      end
      afe_pkg::FmtFour: begin
        bytes[9]  = afe_pkg::AsciiComma;
        bytes[10] = afe_pkg::hex_char(secondary[15:12]);
        bytes[11] = afe_pkg::hex_char(secondary[11:8]);
        bytes[12] = afe_pkg::hex_char(secondary[7:4]);
        bytes[13] = afe_pkg::hex_char(secondary[3:0]);
        tail_base = afe_pkg::IdxW'(14);
      end
      default: begin
        tail_base = afe_pkg::IdxW'(9);
      end
    endcase
    tail[0] = afe_pkg::AsciiSpace;
    tail[1] = afe_pkg::AsciiC;
    tail[2] = afe_pkg::AsciiEq;
    tail[3] = afe_pkg::hex_char(chk[15:12]);
    tail[4] = afe_pkg::hex_char(chk[11:8]);
    tail[5] = afe_pkg::hex_char(chk[7:4]);
    tail[6] = afe_pkg::hex_char(chk[3:0]);
    tail[7] = afe_pkg::AsciiCr;
    for (int i = 0; i < afe_pkg::TailLen; i++) begin
      bytes[tail_base + afe_pkg::IdxW'(i)] = tail[i];
    end
    last_idx = tail_base + afe_pkg::IdxW'(afe_pkg::TailLen - 1);
  end

  always_comb begin
    for (int k = 0; k < afe_pkg::FrameLong; k++) begin
      frame[k].valid    = (afe_pkg::IdxW'(k) <= last_idx);
      frame[k].last     = (afe_pkg::IdxW'(k) == last_idx);
      frame[k].char_out = bytes[k];
    end
  end

endmodule

// File: hdl/ac_link_frame_encoder_top.sv
// top level of the serial command frame encoder
`timescale 1ns / 1ps
// in_ch carries one frame request per word: kind, primary, secondary and
// sec_fmt. out_ch carries the frame as ASCII bytes, one per word,
// with last set on the closing carriage return.
// a request is laid out combinationally and loaded in parallel into a chain of
// 22 byte cells; cell 0 is the output register and the chain shifts one
// cell toward it each time out_ch takes a word.
// latency: the first byte is valid the cycle after the request is taken.
// a frame is 17, 20 or 22 bytes long; a new request is taken in the cycle
// the final byte of the previous frame leaves, so frames run back to back
// with no gap.
// reset clears all cell valid bits; out_ch.valid drops and in_ch.ready is
// high once reset is released.
// when the receiver stalls, the chain holds and in_ch.ready stays low until
// the final byte is taken.
module ac_link_frame_encoder_top (
  input  logic          clk,
  input  logic          rst_n,
  afe_in_if.sink        in_ch,
  afe_out_if.source     out_ch
);

  afe_pkg::cell_t frame [afe_pkg::FrameLong];
  afe_pkg::cell_t cells [afe_pkg::FrameLong];
  logic           out_hs;
  logic           in_hs;

  afe_frame_gen u_gen (
    .kind      (in_ch.kind),
    .primary   (in_ch.primary),
    .secondary (in_ch.secondary),
    .sec_fmt   (in_ch.sec_fmt),
    .frame     (frame)
  );

  assign out_hs      = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !cells[1].valid && (!cells[0].valid || out_ch.ready);
  assign in_hs       = in_ch.valid && in_ch.ready;

  for (genvar k = 0; k < afe_pkg::FrameLong; k++) begin : g_cell
    afe_pkg::cell_t nbr;
    if (k == afe_pkg::FrameLong - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells[k + 1];
    end
    afe_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (in_hs),
      .shift  (out_hs),
      .load_d (frame[k]),
      .nbr_d  (nbr),
      .q      (cells[k])
    );
  end

  assign out_ch.valid    = cells[0].valid;
  assign out_ch.char_out = cells[0].char_out;
  assign out_ch.last     = cells[0].last;

`ifndef SYNTHESIS
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> out_ch.valid && (out_ch.char_out == afe_pkg::AsciiM ||
                               out_ch.char_out == afe_pkg::AsciiS))
    else $error("frame does not open with M or S");

  a_last_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.char_out == afe_pkg::AsciiCr)
    else $error("last byte is not a carriage return");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    cells[1].valid |-> !in_ch.ready)
    else $error("request taken while frame still in chain");

  a_tail_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs && !out_ch.last |=> out_ch.valid)
    else $error("frame ended without a last byte");
`endif

endmodule

// File: sim/ac_link_frame_encoder_checker.sv
// channel monitor that predicts each request's frame bytes and checks the byte stream
`timescale 1ns / 1ps
module ac_link_frame_encoder_checker (
  input  logic clk,
  input  logic rst_n,
  afe_in_if    in_ch,
  afe_out_if   out_ch,
  output int   fail_count,
  output int   bytes_pending,
  output int   requests_seen,
  output int   bytes_seen
);

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_fifo[$];

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? (afe_pkg::AsciiZero + 8'(nib))
                         : (afe_pkg::AsciiUpA + 8'(nib) - 8'd10);
  endfunction

  task automatic push_byte(input logic [7:0] ch, input logic is_last);
    frame_byte_t b;
    b.char_out = ch;
    b.last     = is_last;
    frame_fifo = {frame_fifo, b};
  endtask

  task automatic push_hex(input logic [15:0] value, input int digits);
    for (int d = digits - 1; d >= 0; d--) begin
      push_byte(ascii_hex(value[4*d +: 4]), 1'b0);
    end
  endtask

  task automatic queue_frame(input logic kind, input logic [15:0] prim,
                             input logic [15:0] sec, input logic [1:0] fmt);
    logic [15:0] checksum;
    checksum = ({8'd0, prim[15:8]} + {8'd0, prim[7:0]} +
                {8'd0, sec[15:8]} + {8'd0, sec[7:0]}) ^ 16'hFFFF;
    push_byte(kind ? afe_pkg::AsciiS : afe_pkg::AsciiM, 1'b0);
    push_byte(afe_pkg::AsciiT, 1'b0);
    push_byte(afe_pkg::AsciiSpace, 1'b0);
    push_byte(afe_pkg::AsciiP, 1'b0);
    push_byte(afe_pkg::AsciiEq, 1'b0);
    push_hex(prim, 4);
    // two-digit format prints only the low byte
    if (fmt == afe_pkg::FmtTwo) begin
      push_byte(afe_pkg::AsciiComma, 1'b0);
      push_hex({8'd0, sec[7:0]}, 2);
    end else if (fmt == afe_pkg::FmtFour) begin
      push_byte(afe_pkg::AsciiComma, 1'b0);
      push_hex(sec, 4);
    end
    push_byte(afe_pkg::AsciiSpace, 1'b0);
    push_byte(afe_pkg::AsciiC, 1'b0);
    push_byte(afe_pkg::AsciiEq, 1'b0);
    push_hex(checksum, 4);
    push_byte(afe_pkg::AsciiCr, 1'b1);
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      frame_fifo.delete();
      bytes_pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        queue_frame(in_ch.kind, in_ch.primary, in_ch.secondary, in_ch.sec_fmt);
        requests_seen++;
      end
      if (out_ch.valid && out_ch.ready) begin
        bytes_seen++;
        if (frame_fifo.size() == 0) begin
          $display("%0t: unexpected word char_out=%h last=%b", $time,
                   out_ch.char_out, out_ch.last);
          fail_count++;
        end else begin
          want = frame_fifo.pop_front();
          if (out_ch.char_out !== want.char_out) begin
            $display("%0t: char_out mismatch expected %h actual %h", $time,
                     want.char_out, out_ch.char_out);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last mismatch expected %b actual %b", $time,
                     want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      bytes_pending <= frame_fifo.size();
    end
  end

endmodule

// File: sim/ac_link_frame_encoder_top_tb.sv
// top of the frame encoder testbench: clock, reset, request and stall stimulus, verdict
`timescale 1ns / 1ps
module ac_link_frame_encoder_top_tb;

  localparam logic [1:0] FmtUnused   = 2'd3;
  localparam int         RandomItems = 460;
  localparam int         StallLimit  = 4000;

  typedef enum int {RxAlways, RxPattern, RxSparse, RxMostly} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int fail_count;
  int bytes_pending;
  int requests_seen;
  int bytes_seen;
  int burst_left = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  afe_in_if  in_ch();
  afe_out_if out_ch();

  ac_link_frame_encoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ac_link_frame_encoder_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending),
    .requests_seen (requests_seen),
    .bytes_seen    (bytes_seen)
  );

  always #4 clk = ~clk;

  task automatic send_request(input logic kind, input logic [15:0] prim,
                              input logic [15:0] sec, input logic [1:0] fmt);
    int gap;
    gap = 0;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(0, 2);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.kind      = kind;
    in_ch.primary   = prim;
    in_ch.secondary = sec;
    in_ch.sec_fmt   = fmt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_frames();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // receiver backpressure in stretches of different shapes
  initial begin
    rx_mode_t    mode;
    int          span;
    logic [15:0] pattern;
    out_ch.ready = 1'b0;
    mode    = RxAlways;
    span    = 0;
    pattern = 16'hFFFF;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode    = rx_mode_t'($urandom_range(0, 3));
        span    = $urandom_range(40, 300);
        pattern = 16'($urandom) | 16'h0001;
      end
      span--;
      case (mode)
        RxAlways: begin
          out_ch.ready = 1'b1;
        end
        RxPattern: begin
          out_ch.ready = pattern[0];
          pattern      = {pattern[0], pattern[15:1]};
        end
        RxSparse: begin
          out_ch.ready = ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ch.ready = ($urandom_range(0, 7) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [1:0]  fmt;
    logic [15:0] sec;
    in_ch.valid     = 1'b0;
    in_ch.kind      = 1'b0;
    in_ch.primary   = 16'h0000;
    in_ch.secondary = 16'h0000;
    in_ch.sec_fmt   = afe_pkg::FmtNone;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // field extremes, all formats, unused format code, hidden secondary
    send_request(1'b0, 16'h0000, 16'h0000, afe_pkg::FmtNone);
    send_request(1'b1, 16'hFFFF, 16'hFFFF, afe_pkg::FmtFour);
    send_request(1'b0, 16'hFFFF, 16'hFFFF, afe_pkg::FmtTwo);
    send_request(1'b1, 16'h0000, 16'h0000, afe_pkg::FmtTwo);
    send_request(1'b0, 16'hABCD, 16'hEF01, afe_pkg::FmtFour);
    send_request(1'b1, 16'h1234, 16'h5678, afe_pkg::FmtNone);
    send_request(1'b0, 16'h00FF, 16'hFF00, afe_pkg::FmtTwo);
    send_request(1'b1, 16'hFF00, 16'h00FF, FmtUnused);
    send_request(1'b0, 16'h0000, 16'hFFFF, FmtUnused);
    send_request(1'b1, 16'h89AB, 16'hCDEF, afe_pkg::FmtFour);
    send_request(1'b0, 16'hFFFF, 16'h0000, afe_pkg::FmtNone);
    send_request(1'b1, 16'h0F0F, 16'hF0F0, afe_pkg::FmtTwo);
    send_request(1'b0, 16'hA5A5, 16'h5A5A, afe_pkg::FmtFour);
    send_request(1'b1, 16'h7FFF, 16'h8000, FmtUnused);
    send_request(1'b0, 16'h0001, 16'h0000, afe_pkg::FmtTwo);
    send_request(1'b1, 16'hFFFE, 16'h0001, afe_pkg::FmtFour);
    drain_frames();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == 150 || i == 320) begin
        drain_frames();
      end
      if (i % 60 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      fmt = 2'($urandom_range(0, 3));
      sec = 16'($urandom);
      if (fmt == afe_pkg::FmtNone && $urandom_range(0, 1) == 0) begin
        sec = 16'h0000;
      end
      send_request(1'($urandom), 16'($urandom), sec, fmt);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (bytes_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("covered %0d requests of both kinds and all format codes, %0d bytes checked",
             requests_seen, bytes_seen);
    $display("sender ran in bursts with gaps and drains, receiver stalled in varied patterns");
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
